>>> rtl/core/ertp_pkg.sv
package ertp_pkg;

   // Point and intermediate widths
   localparam int COORD_W = 32;
   localparam int ACC_W   = 40;
   localparam int PROD_W  = 72;
   localparam int TRIG_W  = 32;

   // CORDIC datapath
   localparam int TRIG_STAGES = 16;
   localparam int STAGE_W     = 4;
   localparam int CXY_W       = 34;
   localparam int ANG_W       = 50;
   localparam int RED_W       = 34;
   localparam int RED_STEPS   = 9;
   localparam int SETTLE      = 32;
   localparam int CNT_W       = 6;

   localparam logic signed [CXY_W-1:0] INV_GAIN = CXY_W'(652032874);
   localparam longint DEG_PER_RAD = 64'd62997375797124;

   // 360 degrees with 16 fraction bits, and 128 turns of it
   localparam logic [RED_W-1:0] TURN     = RED_W'(23592960);
   localparam logic [RED_W-1:0] TURN_128 = RED_W'(64'd3019898880);

   localparam logic signed [ANG_W-1:0] ANG_FULL    = ANG_W'(longint'(360) <<< 40);
   localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(longint'(180) <<< 40);
   localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(longint'(90) <<< 40);

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(longint'(1) <<< 29);

   typedef logic signed [ANG_W-1:0] atan_tab_type [TRIG_STAGES];

   typedef enum logic [2:0] {
      CSR_ANGLE_X  = 3'd0,
      CSR_ANGLE_Y  = 3'd1,
      CSR_ANGLE_Z  = 3'd2,
      CSR_OFFSET_X = 3'd3,
      CSR_OFFSET_Y = 3'd4,
      CSR_OFFSET_Z = 3'd5
   } csr_index_type;

   // Settle sequencer commands to the angle units
   typedef struct packed {
      logic               load;
      logic               step;
      logic [3:0]         k;
   } ertp_ctl_type;

   // Truncating quotient of a nonnegative value, by shift and subtract
   function automatic longint div_trunc(input longint n, input longint d);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         r = (r <<< 1) | ((n >>> b) & longint'(1));
         if (r >= d) begin
            r = r - d;
            q = q | (longint'(1) <<< b);
         end
      end
      return q;
   endfunction

   // Arctangent of 2^-i in degrees, 40 fraction bits, truncated series
   function automatic atan_tab_type build_atan();
      atan_tab_type t;
      longint       sum;
      longint       term;
      int           k;
      t[0] = ANG_W'(longint'(45) <<< 40);
      for (int i = 1; i < TRIG_STAGES; i++) begin
         sum = 0;
         k   = 0;
         while ((2 * k + 1) * i < 64) begin
            term = div_trunc(DEG_PER_RAD >>> ((2 * k + 1) * i), longint'(2 * k + 1));
            sum  = ((k & 1) == 1) ? sum - term : sum + term;
            k++;
         end
         t[i] = ANG_W'(sum);
      end
      return t;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan();

   // Q.30 trig times coordinate
   function automatic logic signed [PROD_W-1:0] mul_q(input logic signed [TRIG_W-1:0] t,
                                                      input logic signed [ACC_W-1:0] v);
      return PROD_W'(t) * PROD_W'(v);
   endfunction

   // Drop 30 fraction bits, half up
   function automatic logic signed [ACC_W-1:0] rnd_q(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = (p + ROUND_HALF) >>> 30;
      return s[ACC_W-1:0];
   endfunction

   // Clamp to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_q(input logic signed [ACC_W:0] v);
      logic signed [ACC_W:0] hi;
      logic signed [ACC_W:0] lo;
      hi = (ACC_W+1)'({1'b0, {(COORD_W-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) return hi[COORD_W-1:0];
      if (v < lo) return lo[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

endpackage

>>> rtl/core/ertp_if.sv
interface ertp_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [ertp_pkg::COORD_W-1:0]        in_x;
   logic signed [ertp_pkg::COORD_W-1:0]        in_y;
   logic signed [ertp_pkg::COORD_W-1:0]        in_z;
   modport source (output valid, in_x, in_y, in_z, input ready);
   modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface ertp_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [ertp_pkg::COORD_W-1:0]        out_x;
   logic signed [ertp_pkg::COORD_W-1:0]        out_y;
   logic signed [ertp_pkg::COORD_W-1:0]        out_z;
   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

>>> rtl/core/ertp_cordic_cell.sv
module ertp_cordic_cell (
   input  logic                                  clock,
   input  logic signed [ertp_pkg::CXY_W-1:0]     x_i,
   input  logic signed [ertp_pkg::CXY_W-1:0]     y_i,
   input  logic signed [ertp_pkg::ANG_W-1:0]     z_i,
   input  logic                                  neg_i,
   input  logic [ertp_pkg::STAGE_W-1:0]          shift_i,
   input  logic signed [ertp_pkg::ANG_W-1:0]     atan_i,
   output logic signed [ertp_pkg::CXY_W-1:0]     x_ff,
   output logic signed [ertp_pkg::CXY_W-1:0]     y_ff,
   output logic signed [ertp_pkg::ANG_W-1:0]     z_ff,
   output logic                                  neg_ff
);
   import ertp_pkg::*;

   logic signed [CXY_W-1:0] xs;
   logic signed [CXY_W-1:0] ys;
   logic signed [CXY_W-1:0] x_in;
   logic signed [CXY_W-1:0] y_in;
   logic signed [ANG_W-1:0] z_in;

   // Rotate toward zero residual angle
   always_comb begin
      xs = x_i >>> shift_i;
      ys = y_i >>> shift_i;
      if (z_i >= 0) begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - atan_i;
      end else begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + atan_i;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_i;
   end

endmodule

>>> rtl/core/ertp_angle_unit.sv
module ertp_angle_unit (
   input  logic                                  clock,
   input  ertp_pkg::ertp_ctl_type                ctl,
   input  logic signed [31:0]                    angle,
   output logic signed [ertp_pkg::TRIG_W-1:0]    cos_ff,
   output logic signed [ertp_pkg::TRIG_W-1:0]    sin_ff
);
   import ertp_pkg::*;

   logic [RED_W-1:0]        red_ff;
   logic [RED_W-1:0]        red_in;
   logic [RED_W-1:0]        turn_k;
   logic signed [ANG_W-1:0] z0;
   logic                    neg0;

   logic signed [CXY_W-1:0] x_c   [TRIG_STAGES+1];
   logic signed [CXY_W-1:0] y_c   [TRIG_STAGES+1];
   logic signed [ANG_W-1:0] z_c   [TRIG_STAGES+1];
   logic                    neg_c [TRIG_STAGES+1];

   // Reduce the angle modulo one turn: bias negatives, then subtract turn << k
   always_comb begin
      turn_k = TURN << ctl.k;
      red_in = red_ff;
      if (ctl.load) begin
         red_in = RED_W'(angle) + (angle[31] ? TURN_128 : '0);
      end else if (ctl.step && red_ff >= turn_k) begin
         red_in = red_ff - turn_k;
      end
   end

   always_ff @(posedge clock) begin
      red_ff <= red_in;
   end

   // Move into (-180,180], then fold beyond +-90 with a sign flip
   always_comb begin
      z0   = $signed({1'b0, red_ff[24:0], 24'd0});
      neg0 = 1'b0;
      if (z0 > ANG_HALF) z0 = z0 - ANG_FULL;
      if (z0 > ANG_QUARTER) begin
         z0   = z0 - ANG_HALF;
         neg0 = 1'b1;
      end else if (z0 < -ANG_QUARTER) begin
         z0   = z0 + ANG_HALF;
         neg0 = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_c[0]   <= INV_GAIN;
      y_c[0]   <= '0;
      z_c[0]   <= z0;
      neg_c[0] <= neg0;
   end

   // Chain of rotation cells
   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
      ertp_cordic_cell u_cell (
         .clock   (clock),
         .x_i     (x_c[i]),
         .y_i     (y_c[i]),
         .z_i     (z_c[i]),
         .neg_i   (neg_c[i]),
         .shift_i (STAGE_W'(i)),
         .atan_i  (ATAN_TAB[i]),
         .x_ff    (x_c[i+1]),
         .y_ff    (y_c[i+1]),
         .z_ff    (z_c[i+1]),
         .neg_ff  (neg_c[i+1])
      );
   end

   // Apply the fold sign
   always_ff @(posedge clock) begin
      cos_ff <= neg_c[TRIG_STAGES] ? TRIG_W'(-x_c[TRIG_STAGES]) : TRIG_W'(x_c[TRIG_STAGES]);
      sin_ff <= neg_c[TRIG_STAGES] ? TRIG_W'(-y_c[TRIG_STAGES]) : TRIG_W'(y_c[TRIG_STAGES]);
   end

endmodule

>>> rtl/core/euler_rotate_translate_point.sv
// Transforms one signed Q16.16 point per cycle when not stalled: rotation about
// X, then Y, then Z by the configured angles in degrees, then the configured
// offset, saturated to 32 bits. Each request passes the registered multiply/add
// pipeline stages before its result is presented; results stay in order and a
// stalled output only holds the stages behind it. Sine and cosine come from
// three 16-cell CORDIC chains fed by the angle registers; after reset and after
// any register write the block drops req_ch.ready while the angles are reduced
// modulo 360 (one compare and subtract per cycle) and the chains settle.
module euler_rotate_translate_point (
   input  logic                                clock,
   input  logic                                reset,
   ertp_req_if.sink                            req_ch,
   ertp_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [2:0]                          csr_index,
   input  logic [31:0]                         csr_wdata
);
   import ertp_pkg::*;

   localparam int NSTG = 6;

   logic signed [31:0]       ang_ff [3];
   logic signed [31:0]       ang_in [3];
   logic signed [COORD_W-1:0] off_ff [3];
   logic signed [COORD_W-1:0] off_in [3];
   logic [CNT_W-1:0]         cnt_ff;
   logic [CNT_W-1:0]         cnt_in;
   logic                     busy;
   ertp_ctl_type             ctl;

   logic signed [TRIG_W-1:0] cs [3];
   logic signed [TRIG_W-1:0] sn [3];

   logic [NSTG:1]            vld_ff;
   logic [NSTG:1]            vld_in;
   logic [NSTG:1]            adv;
   logic                     take;

   // Register file writes
   always_comb begin
      ang_in = ang_ff;
      off_in = off_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ANGLE_X:  ang_in[0] = csr_wdata;
            CSR_ANGLE_Y:  ang_in[1] = csr_wdata;
            CSR_ANGLE_Z:  ang_in[2] = csr_wdata;
            CSR_OFFSET_X: off_in[0] = csr_wdata;
            CSR_OFFSET_Y: off_in[1] = csr_wdata;
            CSR_OFFSET_Z: off_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   // Restart the settle count on any write
   always_comb begin
      cnt_in = cnt_ff;
      if (csr_we) cnt_in = '0;
      else if (cnt_ff != CNT_W'(SETTLE)) cnt_in = cnt_ff + 1'b1;
      busy     = (cnt_ff != CNT_W'(SETTLE));
      ctl.load = (cnt_ff == '0);
      ctl.step = (cnt_ff != '0) && (cnt_ff <= CNT_W'(RED_STEPS));
      ctl.k    = 4'(CNT_W'(RED_STEPS) - cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ang_ff[i] <= '0;
            off_ff[i] <= '0;
         end
         cnt_ff <= '0;
      end else begin
         ang_ff <= ang_in;
         off_ff <= off_in;
         cnt_ff <= cnt_in;
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      ertp_angle_unit u_angle (
         .clock  (clock),
         .ctl    (ctl),
         .angle  (ang_ff[a]),
         .cos_ff (cs[a]),
         .sin_ff (sn[a])
      );
   end

   // Stage advance: a stage moves on when empty or when the next one moves
   always_comb begin
      adv[NSTG] = !vld_ff[NSTG] || rsp_ch.ready;
      for (int k = NSTG - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      take = req_ch.valid && req_ch.ready;
      vld_in[1] = adv[1] ? take : vld_ff[1];
      for (int k = 2; k <= NSTG; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_ch.ready = !busy && adv[1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   // Stage 1: products of the input point
   logic signed [PROD_W-1:0] p1_cxy_ff, p1_sxz_ff, p1_sxy_ff, p1_cxz_ff, p1_cyx_ff, p1_syx_ff;
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         p1_cxy_ff <= mul_q(cs[0], ACC_W'(req_ch.in_y));
         p1_sxz_ff <= mul_q(sn[0], ACC_W'(req_ch.in_z));
         p1_sxy_ff <= mul_q(sn[0], ACC_W'(req_ch.in_y));
         p1_cxz_ff <= mul_q(cs[0], ACC_W'(req_ch.in_z));
         p1_cyx_ff <= mul_q(cs[1], ACC_W'(req_ch.in_x));
         p1_syx_ff <= mul_q(sn[1], ACC_W'(req_ch.in_x));
      end
   end

   // Stage 2: X rotation done
   logic signed [ACC_W-1:0] s2_y1_ff, s2_z1_ff, s2_cyx_ff, s2_syx_ff;
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_y1_ff  <= rnd_q(p1_cxy_ff) - rnd_q(p1_sxz_ff);
         s2_z1_ff  <= rnd_q(p1_sxy_ff) + rnd_q(p1_cxz_ff);
         s2_cyx_ff <= rnd_q(p1_cyx_ff);
         s2_syx_ff <= rnd_q(p1_syx_ff);
      end
   end

   // Stage 3: Y rotation products
   logic signed [PROD_W-1:0] p3_cyz_ff, p3_syz_ff;
   logic signed [ACC_W-1:0]  s3_y1_ff, s3_cyx_ff, s3_syx_ff;
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         p3_cyz_ff <= mul_q(cs[1], s2_z1_ff);
         p3_syz_ff <= mul_q(sn[1], s2_z1_ff);
         s3_y1_ff  <= s2_y1_ff;
         s3_cyx_ff <= s2_cyx_ff;
         s3_syx_ff <= s2_syx_ff;
      end
   end

   // Stage 4: Y rotation done
   logic signed [ACC_W-1:0] s4_x2_ff, s4_z2_ff, s4_y1_ff;
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_x2_ff <= s3_cyx_ff + rnd_q(p3_syz_ff);
         s4_z2_ff <= rnd_q(p3_cyz_ff) - s3_syx_ff;
         s4_y1_ff <= s3_y1_ff;
      end
   end

   // Stage 5: Z rotation products
   logic signed [PROD_W-1:0] p5_czx_ff, p5_szy_ff, p5_szx_ff, p5_czy_ff;
   logic signed [ACC_W-1:0]  s5_z2_ff;
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         p5_czx_ff <= mul_q(cs[2], s4_x2_ff);
         p5_szy_ff <= mul_q(sn[2], s4_y1_ff);
         p5_szx_ff <= mul_q(sn[2], s4_x2_ff);
         p5_czy_ff <= mul_q(cs[2], s4_y1_ff);
         s5_z2_ff  <= s4_z2_ff;
      end
   end

   // Stage 6: finish, translate, saturate
   logic signed [COORD_W-1:0] o_x_ff, o_y_ff, o_z_ff;
   always_ff @(posedge clock) begin
      if (adv[6]) begin
         o_x_ff <= sat_q((ACC_W+1)'(rnd_q(p5_czx_ff)) - (ACC_W+1)'(rnd_q(p5_szy_ff))
                         + (ACC_W+1)'(off_ff[0]));
         o_y_ff <= sat_q((ACC_W+1)'(rnd_q(p5_szx_ff)) + (ACC_W+1)'(rnd_q(p5_czy_ff))
                         + (ACC_W+1)'(off_ff[1]));
         o_z_ff <= sat_q((ACC_W+1)'(s5_z2_ff) + (ACC_W+1)'(off_ff[2]));
      end
   end

   assign rsp_ch.valid = vld_ff[NSTG];
   assign rsp_ch.out_x = o_x_ff;
   assign rsp_ch.out_y = o_y_ff;
   assign rsp_ch.out_z = o_z_ff;

endmodule
